/* src/power_loss_alarm_controller_top_macros.svh */
// Assertion macros for the power loss alarm controller.
// Used by power_loss_alarm_controller_top; expects aclk and aresetn in scope.
`ifndef POWER_LOSS_ALARM_CONTROLLER_TOP_MACROS_SVH
`define POWER_LOSS_ALARM_CONTROLLER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PLAC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PLAC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* src/plac_pkg.sv */
// Shared types and constants of the power loss alarm controller.
// No dependencies.
package plac_pkg;

    localparam int REG_W      = 20;
    localparam int TIME_BITS  = 20;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [REG_W-1:0] HOLD_TICKS_RST     = 20'd5000;
    localparam logic [REG_W-1:0] ALARM_INTERVAL_RST = 20'd30000;
    localparam logic [REG_W-1:0] SOFT_PERIOD_RST    = 20'd120000;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_HOLD_TICKS     = 2'd0;
    localparam logic [1:0] REG_ALARM_INTERVAL = 2'd1;
    localparam logic [1:0] REG_SOFT_PERIOD    = 2'd2;

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_ARM     = 2'd1;
    localparam logic [1:0] MODE_DISARM  = 2'd2;

    localparam logic [1:0] ALARM_NONE   = 2'd0;
    localparam logic [1:0] ALARM_SOFT   = 2'd1;
    localparam logic [1:0] ALARM_LOUD   = 2'd2;

    typedef struct packed {
        logic [REG_W-1:0] soft_period;
        logic [REG_W-1:0] alarm_interval;
        logic [REG_W-1:0] hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic signal_active;
        logic button_down;
        logic power_present;
    } tick_t;

    typedef struct packed {
        logic       armed_out;
        logic       signal_sound;
        logic [1:0] alarm_sound;
        logic [1:0] mode_sound;
        logic       red_led;
    } res_t;

endpackage

/* src/power_loss_alarm_controller_top.sv */
// Channel   Dir  Width  Contents
// s_        in   8      one tick: power, button, signal levels
// m_        out  8      one result: LED, sounds, armed status
// apb       in   4/32   hold_ticks, alarm_interval, soft_period
//
// One word per clock unless m_ stalls; words pass the input register, then the result register.
// The tick rules sit between the input register and the result register in one pass.
// Reset is synchronous, active low on aresetn; counters and flags clear, registers load defaults.
// A stalled m_ side holds the result; s_tready drops only when both registers are full.
// Top level; depends on plac_pkg, plac_apb_regs, plac_tick_core and the macros header.
`include "power_loss_alarm_controller_top_macros.svh"

module power_loss_alarm_controller_top
    import plac_pkg::*;
#(
    parameter int TIME_BITS = plac_pkg::TIME_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [0] power_present, [1] button_down, [2] signal_active
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [0] red_led, [2:1] mode_sound, [4:3] alarm_sound,
                                         // [5] signal_sound, [6] armed_out
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t  cfg;
    tick_t in_word_reg;
    logic  in_vld_reg;
    res_t  res;
    res_t  out_word_reg;
    logic  out_vld_reg;
    logic  adv;

    plac_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    plac_tick_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .tick    (in_word_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // advance the held word into the result register when that slot frees up
    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_word_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (adv) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg <= s_tdata[2:0];
        end
        if (adv) begin
            out_word_reg <= res;
        end
    end

    `PLAC_ASSERT(a_alarm_only_armed,
        m_tvalid && out_word_reg.alarm_sound != ALARM_NONE |-> out_word_reg.armed_out,
        "alarm requested while disarmed")
    `PLAC_ASSERT(a_arm_sound_state,
        m_tvalid && out_word_reg.mode_sound == MODE_ARM |-> out_word_reg.armed_out,
        "arming sound without armed state")
    `PLAC_ASSERT(a_disarm_sound_state,
        m_tvalid && out_word_reg.mode_sound == MODE_DISARM |-> !out_word_reg.armed_out,
        "disarming sound while armed")
    `PLAC_ASSERT_ALWAYS(a_ready_when_free,
        aresetn && $past(aresetn) && !out_vld_reg |-> s_tready,
        "input stalled with free result slot")

endmodule

/* src/plac_apb_regs.sv */
// APB configuration registers of the power loss alarm controller.
// Depends on plac_pkg.
module plac_apb_regs
    import plac_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_ticks     <= HOLD_TICKS_RST;
            cfg_reg.alarm_interval <= ALARM_INTERVAL_RST;
            cfg_reg.soft_period    <= SOFT_PERIOD_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_HOLD_TICKS:     cfg_reg.hold_ticks     <= pwdata[REG_W-1:0];
                REG_ALARM_INTERVAL: cfg_reg.alarm_interval <= pwdata[REG_W-1:0];
                REG_SOFT_PERIOD:    cfg_reg.soft_period    <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_HOLD_TICKS:     prdata = DATA_W'(cfg_reg.hold_ticks);
            REG_ALARM_INTERVAL: prdata = DATA_W'(cfg_reg.alarm_interval);
            REG_SOFT_PERIOD:    prdata = DATA_W'(cfg_reg.soft_period);
            default:            prdata = '0;
        endcase
    end

endmodule

/* src/plac_tick_core.sv */
// Per-tick state and rules of the power loss alarm controller.
// Depends on plac_pkg.
module plac_tick_core
    import plac_pkg::*;
#(
    parameter int TIME_BITS = plac_pkg::TIME_BITS
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  adv,
    input  tick_t tick,
    input  cfg_t  cfg,
    output res_t  res
);

    localparam int CMP_W = (TIME_BITS > REG_W) ? TIME_BITS : REG_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic started_reg, started_next;
    logic armed_reg, armed_next;
    logic outage_reg, outage_next;
    logic led_reg, led_next;
    logic press_reg, press_next;
    logic [TIME_BITS-1:0] hold_cnt_reg, hold_cnt_next;
    logic [TIME_BITS-1:0] outage_cnt_reg, outage_cnt_next;
    logic [TIME_BITS-1:0] since_alarm_reg, since_alarm_next;

    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
        sat_inc = (v == TIME_MAX) ? v : v + 1'b1;
    endfunction

    always_comb begin
        started_next     = started_reg;
        armed_next       = armed_reg;
        outage_next      = outage_reg;
        led_next         = led_reg;
        press_next       = press_reg;
        hold_cnt_next    = hold_cnt_reg;
        outage_cnt_next  = outage_cnt_reg;
        since_alarm_next = since_alarm_reg;
        res              = '0;

        if (outage_reg) begin
            outage_cnt_next  = sat_inc(outage_cnt_reg);
            since_alarm_next = sat_inc(since_alarm_reg);
        end

        // first tick: arm on power, else disarm
        if (!started_reg) begin
            started_next   = 1'b1;
            armed_next     = tick.power_present;
            outage_next    = 1'b0;
            led_next       = tick.power_present;
            res.mode_sound = tick.power_present ? MODE_ARM : MODE_DISARM;
        end

        if (tick.power_present) begin
            if (outage_next) begin
                outage_next = 1'b0;
                led_next    = 1'b1;
            end
        end else if (armed_next && !outage_next) begin
            outage_next      = 1'b1;
            outage_cnt_next  = '0;
            since_alarm_next = '0;
            led_next         = 1'b1;
        end

        if (tick.button_down) begin
            if (!press_reg) begin
                press_next    = 1'b1;
                hold_cnt_next = '0;
            end else begin
                hold_cnt_next = sat_inc(hold_cnt_reg);
                if (CMP_W'(hold_cnt_next) >= CMP_W'(cfg.hold_ticks)) begin
                    armed_next     = !armed_next;
                    outage_next    = 1'b0;
                    led_next       = armed_next;
                    res.mode_sound = armed_next ? MODE_ARM : MODE_DISARM;
                    press_next     = 1'b0;
                end
            end
        end else begin
            press_next = 1'b0;
        end

        if (armed_next && outage_next &&
            CMP_W'(since_alarm_next) >= CMP_W'(cfg.alarm_interval)) begin
            res.alarm_sound  = (CMP_W'(outage_cnt_next) <= CMP_W'(cfg.soft_period))
                               ? ALARM_SOFT : ALARM_LOUD;
            since_alarm_next = '0;
        end

        res.red_led      = led_next;
        res.signal_sound = tick.signal_active;
        res.armed_out    = armed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg     <= 1'b0;
            armed_reg       <= 1'b0;
            outage_reg      <= 1'b0;
            led_reg         <= 1'b0;
            press_reg       <= 1'b0;
            hold_cnt_reg    <= '0;
            outage_cnt_reg  <= '0;
            since_alarm_reg <= '0;
        end else if (adv) begin
            started_reg     <= started_next;
            armed_reg       <= armed_next;
            outage_reg      <= outage_next;
            led_reg         <= led_next;
            press_reg       <= press_next;
            hold_cnt_reg    <= hold_cnt_next;
            outage_cnt_reg  <= outage_cnt_next;
            since_alarm_reg <= since_alarm_next;
        end
    end

endmodule
